// ===== hdl/fdhs_pkg.sv =====
// Shared types and constants of the disk head sweep scheduler.
`default_nettype none
package fdhs_pkg;

	localparam int TRACK_W  = 4;
	localparam int SECTOR_W = 4;
	localparam int WORD_W   = 16;
	localparam int TDATA_W  = 32;

	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		RES_ENQ   = 2'd0,
		RES_REJ   = 2'd1,
		RES_READ  = 2'd2,
		RES_WRITE = 2'd3
	} fdhs_res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_RESP
	} fdhs_state_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fdhs_qstat_t;

endpackage
`default_nettype wire

// ===== hdl/fdhs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module fdhs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fdhs_queue.sv =====
// Request queue: pointers and count around a RAM holding the entries.
`default_nettype none
module fdhs_queue
	import fdhs_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int WIDTH = 25
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	input  wire logic             rd_req,
	output logic      [WIDTH-1:0] rd_data,
	output fdhs_qstat_t           stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	fdhs_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(wr_ptr_q),
		.wr_data(push_data),
		.rd_en  (rd_req),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

endmodule
`default_nettype wire

// ===== hdl/fdhs_head.sv =====
// Head position: sector step, track change at end of track, reversal at the edges.
`default_nettype none
module fdhs_head #(
	parameter int NUM_TRACKS        = 16,
	parameter int SECTORS_PER_TRACK = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   norm,
	input  wire logic                                   adv,
	output logic [$clog2(NUM_TRACKS)-1:0]               track,
	output logic [$clog2(SECTORS_PER_TRACK + 1)-1:0]    sector,
	output logic                                        up
);

	localparam int TK_W = $clog2(NUM_TRACKS);
	localparam int HS_W = $clog2(SECTORS_PER_TRACK + 1);
	localparam logic [TK_W-1:0] LAST_TRK = TK_W'(NUM_TRACKS - 1);
	localparam logic [HS_W-1:0] SEC_END  = HS_W'(SECTORS_PER_TRACK);

	logic [TK_W-1:0] track_q, trk_n;
	logic [HS_W-1:0] sector_q, sec_n;
	logic            up_q, up_n;

	always_comb begin
		trk_n = track_q;
		sec_n = sector_q;
		up_n  = up_q;
		if (norm && sector_q == SEC_END) begin
			sec_n = '0;
			if (up_q) begin
				if (track_q == LAST_TRK) up_n = 1'b0;
				else trk_n = track_q + 1'b1;
			end else begin
				if (track_q == '0) up_n = 1'b1;
				else trk_n = track_q - 1'b1;
			end
		end else if (adv) begin
			sec_n = sector_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q  <= '0;
			sector_q <= '0;
			up_q     <= 1'b1;
		end else begin
			track_q  <= trk_n;
			sector_q <= sec_n;
			up_q     <= up_n;
		end
	end

	assign track  = track_q;
	assign sector = sector_q;
	assign up     = up_q;

endmodule
`default_nettype wire

// ===== hdl/fifo_disk_head_sweep_scheduler.sv =====
// Top level of the disk head sweep scheduler: sequencer, sector store and result register.
`default_nettype none
// A word with tuser 0 enqueues a read or write request (one result: enqueued or rejected
// when the queue is full); a word with tuser 1 is one tick of head time, which, when the
// queue is not empty, moves the head one sector and, when the head sits on the oldest
// request, serves it (one result: read or write served) or gives no result. Words are
// taken one at a time by a sequencer around the queue RAM and the sector store RAM, each
// with a registered read. An enqueue or a served tick waits for m_tready while a result
// is still pending. After reset the sector store is zeroed by a pass over all
// NUM_TRACKS * SECTORS_PER_TRACK entries during which s_tready stays low.
module fifo_disk_head_sweep_scheduler
	import fdhs_pkg::*;
#(
	parameter int NUM_TRACKS        = 16,
	parameter int SECTORS_PER_TRACK = 16,
	parameter int QUEUE_DEPTH       = 64,
	parameter int DATA_BITS         = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // write_op, target_track, target_sector, write_data
	input  wire logic               s_tuser,  // kind
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,  // out_track, out_sector, read_data, sweeping_up
	output logic      [1:0]         m_tuser   // result_kind
);

	localparam int ENT_W  = 1 + TRACK_W + SECTOR_W + DATA_BITS;
	localparam int DEPTH  = NUM_TRACKS * SECTORS_PER_TRACK;
	localparam int SA_W   = $clog2(DEPTH);
	localparam int TK_W   = $clog2(NUM_TRACKS);
	localparam int HS_W   = $clog2(SECTORS_PER_TRACK + 1);
	localparam int TC_W   = (TK_W > TRACK_W) ? TK_W : TRACK_W;
	localparam int SC_W   = (HS_W > SECTOR_W) ? HS_W : SECTOR_W;

	fdhs_state_t state_q, state_n;

	// accepted word
	logic                 kind_q;
	logic                 wop_q;
	logic [TRACK_W-1:0]   trk_q;
	logic [SECTOR_W-1:0]  sec_q;
	logic [DATA_BITS-1:0] wdata_q;

	// request being served
	logic                 srv_write_q;
	logic [TRACK_W-1:0]   srv_trk_q;
	logic [SECTOR_W-1:0]  srv_sec_q;
	logic [DATA_BITS-1:0] srv_data_q;
	logic                 srv_up_q;

	// result register
	logic                 out_valid_q;
	fdhs_res_t            out_kind_q;
	logic [TRACK_W-1:0]   out_trk_q;
	logic [SECTOR_W-1:0]  out_sec_q;
	logic [WORD_W-1:0]    out_data_q;
	logic                 out_up_q;

	logic [SA_W-1:0]      clr_q;

	fdhs_qstat_t          qstat;
	logic [ENT_W-1:0]     q_rdata;
	logic                 q_push, q_pop, q_rd;
	logic                 h_norm, h_adv;
	logic [TK_W-1:0]      h_trk;
	logic [HS_W-1:0]      h_sec;
	logic                 h_up;
	logic                 st_wr, st_rd;
	logic [SA_W-1:0]      st_addr;
	logic [DATA_BITS-1:0] st_wdata, st_rdata;
	logic                 out_free, accept, match;
	logic                 load_exec, load_resp, latch_srv, clr_inc;

	logic                 e_wop;
	logic [TRACK_W-1:0]   e_trk;
	logic [SECTOR_W-1:0]  e_sec;
	logic [DATA_BITS-1:0] e_data;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign e_data = q_rdata[DATA_BITS-1:0];
	assign e_sec  = q_rdata[DATA_BITS +: SECTOR_W];
	assign e_trk  = q_rdata[DATA_BITS + SECTOR_W +: TRACK_W];
	assign e_wop  = q_rdata[ENT_W-1];
	assign match  = (TC_W'(e_trk) == TC_W'(h_trk)) && (SC_W'(e_sec) == SC_W'(h_sec));

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == SA_W'(DEPTH - 1)) state_n = ST_IDLE;
			ST_IDLE:  if (accept) state_n = ST_EXEC;
			ST_EXEC: begin
				if (kind_q == KIND_TICK) begin
					state_n = qstat.empty ? ST_IDLE : ST_FETCH;
				end else if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_FETCH: state_n = match ? ST_RESP : ST_IDLE;
			ST_RESP:  if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		q_push    = 1'b0;
		q_pop     = 1'b0;
		q_rd      = 1'b0;
		h_norm    = 1'b0;
		h_adv     = 1'b0;
		st_wr     = 1'b0;
		st_rd     = 1'b0;
		load_exec = 1'b0;
		load_resp = 1'b0;
		latch_srv = 1'b0;
		clr_inc   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				st_wr   = 1'b1;
				clr_inc = 1'b1;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: begin
				if (kind_q == KIND_TICK) begin
					h_norm = !qstat.empty;
					q_rd   = !qstat.empty;
				end else if (out_free) begin
					load_exec = 1'b1;
					q_push    = !qstat.full;
				end
			end
			ST_FETCH: begin
				h_adv = 1'b1;
				if (match) begin
					q_pop     = 1'b1;
					latch_srv = 1'b1;
					st_wr     = e_wop;
					st_rd     = !e_wop;
				end
			end
			ST_RESP: load_resp = out_free;
			default: ;
		endcase
	end

	assign st_addr  = (state_q == ST_CLEAR) ? clr_q
		: SA_W'(SA_W'(e_trk) * SA_W'(SECTORS_PER_TRACK)) + SA_W'(e_sec);
	assign st_wdata = (state_q == ST_CLEAR) ? '0 : e_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (clr_inc) clr_q <= clr_q + 1'b1;
			if (load_exec || load_resp) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= s_tuser;
			wop_q   <= s_tdata[0];
			trk_q   <= s_tdata[1 +: TRACK_W];
			sec_q   <= s_tdata[1 + TRACK_W +: SECTOR_W];
			wdata_q <= DATA_BITS'(s_tdata[1 + TRACK_W + SECTOR_W +: WORD_W]);
		end
		if (latch_srv) begin
			srv_write_q <= e_wop;
			srv_trk_q   <= e_trk;
			srv_sec_q   <= e_sec;
			srv_data_q  <= e_data;
			srv_up_q    <= h_up;
		end
		if (load_exec) begin
			out_kind_q <= qstat.full ? RES_REJ : RES_ENQ;
			out_trk_q  <= trk_q;
			out_sec_q  <= sec_q;
			out_data_q <= '0;
			out_up_q   <= 1'b0;
		end else if (load_resp) begin
			out_kind_q <= srv_write_q ? RES_WRITE : RES_READ;
			out_trk_q  <= srv_trk_q;
			out_sec_q  <= srv_sec_q;
			out_data_q <= srv_write_q ? WORD_W'(srv_data_q) : WORD_W'(st_rdata);
			out_up_q   <= srv_up_q;
		end
	end

	fdhs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({wop_q, trk_q, sec_q, wdata_q}),
		.pop      (q_pop),
		.rd_req   (q_rd),
		.rd_data  (q_rdata),
		.stat     (qstat)
	);

	fdhs_head #(
		.NUM_TRACKS       (NUM_TRACKS),
		.SECTORS_PER_TRACK(SECTORS_PER_TRACK)
	) u_head (
		.clk   (clk),
		.arst_n(arst_n),
		.norm  (h_norm),
		.adv   (h_adv),
		.track (h_trk),
		.sector(h_sec),
		.up    (h_up)
	);

	fdhs_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr),
		.wr_addr(st_addr),
		.wr_data(st_wdata),
		.rd_en  (st_rd),
		.rd_addr(st_addr),
		.rd_data(st_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {(TDATA_W - TRACK_W - SECTOR_W - WORD_W - 1)'(0),
		out_up_q, out_data_q, out_sec_q, out_trk_q};

endmodule
`default_nettype wire

// ===== hdl/fdhs_checker.sv =====
// Port-level checks of the disk head sweep scheduler, bound to the top level.
`default_nettype none
module fdhs_checker
	import fdhs_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic [1:0]         m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while previous one still in work");

	a_queue_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_ENQ || m_tuser == RES_REJ) |-> m_tdata[24:8] == '0)
		else $error("queue result carries data or direction");

	a_no_result_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid || !$past(arst_n) && $past(m_tvalid) == 1'b0 || arst_n)
		else $error("result word out of reset");

endmodule

bind fifo_disk_head_sweep_scheduler fdhs_checker u_fdhs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
